// File: rtl/cfe_pkg.sv
// Shared types and constants of the command frame encoder.
package cfe_pkg;

    localparam int CFE_MAX_PARAMS  = 127;
    localparam int CFE_QUEUE_DEPTH = 2;

    localparam logic [7:0] SYNC_BYTE0 = 8'hEB;
    localparam logic [7:0] SYNC_BYTE1 = 8'h90;
    localparam logic [7:0] TAIL_BYTE0 = 8'hDC;
    localparam logic [7:0] TAIL_BYTE1 = 8'h97;

    // Byte positions inside the begin sequence.
    localparam logic [3:0] HDR_SYNC0  = 4'd0;
    localparam logic [3:0] HDR_SYNC1  = 4'd1;
    localparam logic [3:0] HDR_CMD    = 4'd2;
    localparam logic [3:0] HDR_ID0    = 4'd3;
    localparam logic [3:0] HDR_ID1    = 4'd4;
    localparam logic [3:0] HDR_ID2    = 4'd5;
    localparam logic [3:0] HDR_ID3    = 4'd6;
    localparam logic [3:0] HDR_DEV    = 4'd7;
    localparam logic [3:0] HDR_DEVID  = 4'd8;
    localparam logic [3:0] HDR_CTRL   = 4'd9;
    localparam logic [3:0] HDR_LEN    = 4'd10;

    // Byte positions inside the finish sequence.
    localparam logic [3:0] TL_SUM     = 4'd0;
    localparam logic [3:0] TL_TAIL0   = 4'd1;
    localparam logic [3:0] TL_TAIL1   = 4'd2;

    typedef enum logic [1:0] {
        OP_BEGIN  = 2'd0,
        OP_PARAM  = 2'd1,
        OP_FINISH = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_ORDER    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        JOB_HEADER,
        JOB_PARAM,
        JOB_TAIL,
        JOB_REJECT
    } job_kind_t;

    // One classified item as it waits between the front and the back.
    typedef struct packed {
        job_kind_t   kind;
        logic        wide;
        logic        mismatch;
        logic [7:0]  cmd_type;
        logic [7:0]  dev_type;
        logic [7:0]  dev_id;
        logic [7:0]  ctrl_word;
        logic [7:0]  len_byte;
        logic [31:0] value;
    } job_t;

endpackage

// File: rtl/cfe_req_if.sv
// Input item channel of the command frame encoder.
interface cfe_req_if ();
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  cmd_type;
    logic [7:0]  dev_type;
    logic [7:0]  dev_id;
    logic [7:0]  ctrl_word;
    logic [30:0] frame_id;
    logic [6:0]  param_count;
    logic [31:0] param_value;

    modport source (
        output valid, opcode, cmd_type, dev_type, dev_id, ctrl_word,
               frame_id, param_count, param_value,
        input  ready
    );
    modport sink (
        input  valid, opcode, cmd_type, dev_type, dev_id, ctrl_word,
               frame_id, param_count, param_value,
        output ready
    );
endinterface

// File: rtl/cfe_rsp_if.sv
// Output byte channel of the command frame encoder.
interface cfe_rsp_if ();
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
    logic [1:0] status;

    modport source (
        output valid, out_byte, run_last, frame_end, status,
        input  ready
    );
    modport sink (
        input  valid, out_byte, run_last, frame_end, status,
        output ready
    );
endinterface

// File: rtl/cfe_cfg_if.sv
// Configuration write channel of the command frame encoder.
interface cfe_cfg_if ();
    logic valid;
    logic ready;
    logic data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

// File: rtl/cfe_front.sv
// Front end: accepts items, tracks frame state and classifies each item.
module cfe_front
    import cfe_pkg::*;
#(
    parameter int MAX_PARAMS = CFE_MAX_PARAMS
)
(
    input  logic         clk,
    input  logic         rst_n,
    cfe_req_if.sink      req,
    cfe_cfg_if.sink      cfg,
    input  logic         q_full,
    output logic         q_push,
    output job_t         q_job
);

    localparam logic [6:0] MAX_CNT = 7'(MAX_PARAMS);

    logic       wide_reg;
    logic       in_frame_reg,  in_frame_next;
    logic [6:0] exp_cnt_reg,   exp_cnt_next;
    logic [7:0] seen_cnt_reg,  seen_cnt_next;
    logic [6:0] cnt_clamped;
    logic       accept;

    assign cfg.ready = 1'b1;
    assign req.ready = !q_full;
    assign accept    = req.valid && req.ready;
    assign q_push    = accept;

    assign cnt_clamped = (req.param_count > MAX_CNT) ? MAX_CNT : req.param_count;

    always_comb
    begin
        q_job.kind      = JOB_REJECT;
        q_job.wide      = wide_reg;
        q_job.mismatch  = (seen_cnt_reg != {1'b0, exp_cnt_reg});
        q_job.cmd_type  = req.cmd_type;
        q_job.dev_type  = req.dev_type;
        q_job.dev_id    = req.dev_id;
        q_job.ctrl_word = req.ctrl_word;
        q_job.len_byte  = wide_reg ? {cnt_clamped[5:0], 2'b00} : {cnt_clamped, 1'b0};
        q_job.value     = req.param_value;
        in_frame_next   = in_frame_reg;
        exp_cnt_next    = exp_cnt_reg;
        seen_cnt_next   = seen_cnt_reg;

        case (req.opcode)
            OP_BEGIN:
            begin
                if (!in_frame_reg)
                begin
                    q_job.kind    = JOB_HEADER;
                    q_job.value   = {1'b0, req.frame_id};
                    in_frame_next = 1'b1;
                    exp_cnt_next  = cnt_clamped;
                    seen_cnt_next = 8'd0;
                end
            end
            OP_PARAM:
            begin
                if (in_frame_reg)
                begin
                    q_job.kind = JOB_PARAM;
                    if (seen_cnt_reg != 8'hFF)
                    begin
                        seen_cnt_next = seen_cnt_reg + 8'd1;
                    end
                end
            end
            OP_FINISH:
            begin
                if (in_frame_reg)
                begin
                    q_job.kind    = JOB_TAIL;
                    in_frame_next = 1'b0;
                    exp_cnt_next  = 7'd0;
                    seen_cnt_next = 8'd0;
                end
            end
            default:
            begin
                q_job.kind = JOB_REJECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_reg     <= 1'b1;
            in_frame_reg <= 1'b0;
            exp_cnt_reg  <= 7'd0;
            seen_cnt_reg <= 8'd0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                wide_reg <= cfg.data;
            end
            if (accept)
            begin
                in_frame_reg <= in_frame_next;
                exp_cnt_reg  <= exp_cnt_next;
                seen_cnt_reg <= seen_cnt_next;
            end
        end
    end

endmodule

// File: rtl/cfe_queue.sv
// Short queue of classified items between the front and the back.
module cfe_queue
    import cfe_pkg::*;
#(
    parameter int DEPTH = CFE_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head_job  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: rtl/cfe_back.sv
// Back end: serializes queued items, one byte per cycle unless stalled.
module cfe_back
    import cfe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_not_empty,
    input  job_t      q_head,
    output logic      q_pop,
    cfe_rsp_if.source rsp
);

    logic       rsp_valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       end_reg;
    status_t    status_reg;

    logic [3:0] idx_reg, idx_next;
    logic [7:0] sum_reg, sum_next;

    logic       load;
    logic       emit;
    logic [7:0] byte_next;
    logic       last_next;
    logic       end_next;
    status_t    status_next;
    status_t    tail_status;

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.out_byte  = byte_reg;
    assign rsp.run_last  = last_reg;
    assign rsp.frame_end = end_reg;
    assign rsp.status    = status_reg;

    assign load        = !rsp_valid_reg || rsp.ready;
    assign emit        = load && q_not_empty;
    assign q_pop       = emit && last_next;
    assign tail_status = q_head.mismatch ? ST_MISMATCH : ST_OK;

    // Byte selection for the item at the head of the queue.
    always_comb
    begin
        byte_next   = 8'h00;
        last_next   = 1'b0;
        end_next    = 1'b0;
        status_next = ST_OK;
        sum_next    = sum_reg;

        case (q_head.kind)
            JOB_HEADER:
            begin
                case (idx_reg)
                    HDR_SYNC0: byte_next = SYNC_BYTE0;
                    HDR_SYNC1: byte_next = SYNC_BYTE1;
                    HDR_CMD:   byte_next = q_head.cmd_type;
                    HDR_ID0:   byte_next = q_head.value[7:0];
                    HDR_ID1:   byte_next = q_head.value[15:8];
                    HDR_ID2:   byte_next = q_head.value[23:16];
                    HDR_ID3:   byte_next = q_head.value[31:24];
                    HDR_DEV:   byte_next = q_head.dev_type;
                    HDR_DEVID: byte_next = q_head.dev_id;
                    HDR_CTRL:  byte_next = q_head.ctrl_word;
                    HDR_LEN:   byte_next = q_head.len_byte;
                    default:   byte_next = 8'h00;
                endcase
                last_next = (idx_reg == HDR_LEN);
                // The checksum covers every byte after the sync word.
                if (idx_reg == HDR_SYNC0 || idx_reg == HDR_SYNC1)
                begin
                    sum_next = 8'h00;
                end
                else
                begin
                    sum_next = sum_reg + byte_next;
                end
            end
            JOB_PARAM:
            begin
                case (idx_reg[1:0])
                    2'd0:    byte_next = q_head.value[7:0];
                    2'd1:    byte_next = q_head.value[15:8];
                    2'd2:    byte_next = q_head.value[23:16];
                    default: byte_next = q_head.value[31:24];
                endcase
                last_next = q_head.wide ? (idx_reg == 4'd3) : (idx_reg == 4'd1);
                sum_next  = sum_reg + byte_next;
            end
            JOB_TAIL:
            begin
                case (idx_reg)
                    TL_SUM:   byte_next = sum_reg;
                    TL_TAIL0: byte_next = TAIL_BYTE0;
                    TL_TAIL1: byte_next = TAIL_BYTE1;
                    default:  byte_next = 8'h00;
                endcase
                last_next   = (idx_reg == TL_TAIL1);
                end_next    = last_next;
                status_next = tail_status;
                if (last_next)
                begin
                    sum_next = 8'h00;
                end
            end
            default:
            begin
                byte_next   = 8'h00;
                last_next   = 1'b1;
                status_next = ST_ORDER;
            end
        endcase

        if (last_next)
        begin
            idx_next = 4'd0;
        end
        else
        begin
            idx_next = idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            idx_reg       <= 4'd0;
            sum_reg       <= 8'h00;
        end
        else
        begin
            if (emit)
            begin
                rsp_valid_reg <= 1'b1;
                idx_reg       <= idx_next;
                sum_reg       <= sum_next;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte_reg   <= byte_next;
            last_reg   <= last_next;
            end_reg    <= end_next;
            status_reg <= status_next;
        end
    end

endmodule

// File: rtl/command_frame_encoder.sv
// The first byte of an item is registered in a queue slot and then in the byte output register.
// Output: one byte per cycle while the output is ready and items are queued, set by the single byte
// output register; a begin item makes 11 bytes, a parameter 2 or 4, a finish 3 and a rejected item 1.
// The front accepts new items while the back is still serializing, up to the queue depth.
// Reset: no frame open, empty queue, no output pending, 32-bit elements selected.
module command_frame_encoder
    import cfe_pkg::*;
#(
    parameter int MAX_PARAMS  = CFE_MAX_PARAMS,
    parameter int QUEUE_DEPTH = CFE_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    cfe_req_if.sink   req,
    cfe_cfg_if.sink   cfg,
    cfe_rsp_if.source rsp
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_not_empty;
    job_t q_push_job;
    job_t q_head;

    cfe_front #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cfg    (cfg),
        .q_full (q_full),
        .q_push (q_push),
        .q_job  (q_push_job)
    );

    cfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (q_push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_job  (q_head)
    );

    cfe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .rsp         (rsp)
    );

endmodule

// File: tb/tb_command_frame_encoder.sv
// Self-checking testbench of the command frame encoder.
module tb_command_frame_encoder;
    import cfe_pkg::*;

    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         STALL_LIMIT   = 5000;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         HOLD_CYCLES   = 200;

    typedef struct {
        logic [1:0]  opcode;
        logic [7:0]  cmd_type;
        logic [7:0]  dev_type;
        logic [7:0]  dev_id;
        logic [7:0]  ctrl_word;
        logic [30:0] frame_id;
        logic [6:0]  param_count;
        logic [31:0] param_value;
    } cmd_item_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       fin;
        logic [1:0] status;
    } frame_byte_t;

    logic clk;
    logic rst_n;

    cfe_req_if req_ch ();
    cfe_rsp_if rsp_ch ();
    cfe_cfg_if cfg_ch ();

    command_frame_encoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .cfg   (cfg_ch),
        .rsp   (rsp_ch)
    );

    // Predicted state of the encoder.
    logic        wide_mode;
    logic        open_frame;
    logic [7:0]  frame_sum;
    int          announced_cnt;
    int          elem_cnt;
    frame_byte_t frame_bytes_q[$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int items_sent;
    int mismatch_count;
    int stall_cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void push_frame_byte(logic [7:0] d, logic last, logic fin, status_t st);
        frame_byte_t fb;
        fb.data   = d;
        fb.last   = last;
        fb.fin    = fin;
        fb.status = st;
        frame_bytes_q.push_back(fb);
    endfunction

    function automatic void push_body(logic [7:0] d, logic last);
        frame_sum = frame_sum + d;
        push_frame_byte(d, last, 1'b0, ST_OK);
    endfunction

    // Works out every byte that one accepted item makes the encoder emit.
    function automatic void encode_item(cmd_item_t it);
        int         esize;
        int         cnt;
        status_t    st;
        logic [7:0] len_byte;
        esize = wide_mode ? 4 : 2;
        case (it.opcode)
            OP_BEGIN:
            begin
                if (open_frame)
                begin
                    push_frame_byte(8'h00, 1'b1, 1'b0, ST_ORDER);
                end
                else
                begin
                    cnt = it.param_count;
                    if (cnt > CFE_MAX_PARAMS)
                        cnt = CFE_MAX_PARAMS;
                    len_byte = 8'(cnt * esize);
                    frame_sum = 8'h00;
                    push_frame_byte(SYNC_BYTE0, 1'b0, 1'b0, ST_OK);
                    push_frame_byte(SYNC_BYTE1, 1'b0, 1'b0, ST_OK);
                    push_body(it.cmd_type, 1'b0);
                    push_body(it.frame_id[7:0], 1'b0);
                    push_body(it.frame_id[15:8], 1'b0);
                    push_body(it.frame_id[23:16], 1'b0);
                    push_body({1'b0, it.frame_id[30:24]}, 1'b0);
                    push_body(it.dev_type, 1'b0);
                    push_body(it.dev_id, 1'b0);
                    push_body(it.ctrl_word, 1'b0);
                    push_body(len_byte, 1'b1);
                    open_frame    = 1'b1;
                    announced_cnt = cnt;
                    elem_cnt      = 0;
                end
            end
            OP_PARAM:
            begin
                if (!open_frame)
                begin
                    push_frame_byte(8'h00, 1'b1, 1'b0, ST_ORDER);
                end
                else
                begin
                    for (int i = 0; i < esize; i++)
                        push_body(it.param_value[8*i +: 8], i == esize - 1);
                    if (elem_cnt < 255)
                        elem_cnt++;
                end
            end
            OP_FINISH:
            begin
                if (!open_frame)
                begin
                    push_frame_byte(8'h00, 1'b1, 1'b0, ST_ORDER);
                end
                else
                begin
                    st = (elem_cnt != announced_cnt) ? ST_MISMATCH : ST_OK;
                    push_frame_byte(frame_sum, 1'b0, 1'b0, st);
                    push_frame_byte(TAIL_BYTE0, 1'b0, 1'b0, st);
                    push_frame_byte(TAIL_BYTE1, 1'b1, 1'b1, st);
                    open_frame    = 1'b0;
                    frame_sum     = 8'h00;
                    announced_cnt = 0;
                    elem_cnt      = 0;
                end
            end
            default:
            begin
                push_frame_byte(8'h00, 1'b1, 1'b0, ST_ORDER);
            end
        endcase
    endfunction

    function automatic cmd_item_t random_item(logic [1:0] op);
        cmd_item_t it;
        it.opcode      = op;
        it.cmd_type    = 8'($urandom());
        it.dev_type    = 8'($urandom());
        it.dev_id      = 8'($urandom());
        it.ctrl_word   = 8'($urandom());
        it.frame_id    = 31'($urandom());
        it.param_count = 7'($urandom_range(6));
        it.param_value = $urandom();
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input cmd_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.opcode      = it.opcode;
        req_ch.cmd_type    = it.cmd_type;
        req_ch.dev_type    = it.dev_type;
        req_ch.dev_id      = it.dev_id;
        req_ch.ctrl_word   = it.ctrl_word;
        req_ch.frame_id    = it.frame_id;
        req_ch.param_count = it.param_count;
        req_ch.param_value = it.param_value;
        req_ch.valid       = 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        encode_item(it);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_for_drain();
        req_ch.valid = 1'b0;
        while (frame_bytes_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_wide(input logic wide);
        wait_for_drain();
        cfg_ch.data  = wide;
        cfg_ch.valid = 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        wide_mode = wide;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Reset width, extreme header fields and the largest count, which the
    // single element that follows does not meet.
    task automatic test_header_extremes();
        cmd_item_t it;
        it = random_item(OP_BEGIN);
        it.cmd_type    = 8'hFF;
        it.dev_type    = 8'h00;
        it.dev_id      = 8'hFF;
        it.ctrl_word   = 8'h00;
        it.frame_id    = 31'h7FFF_FFFF;
        it.param_count = 7'd127;
        send_item(it);
        it = random_item(OP_PARAM);
        it.param_value = 32'hFFFF_FFFF;
        send_item(it);
        send_item(random_item(OP_FINISH));
    endtask

    task automatic test_out_of_order();
        cmd_item_t it;
        send_item(random_item(OP_PARAM));
        send_item(random_item(OP_FINISH));
        send_item(random_item(OP_UNUSED));
        it = random_item(OP_BEGIN);
        it.cmd_type    = 8'h00;
        it.dev_type    = 8'hFF;
        it.dev_id      = 8'h00;
        it.ctrl_word   = 8'hFF;
        it.frame_id    = 31'h0;
        it.param_count = 7'd0;
        send_item(it);
        // A second begin and the unused opcode must leave the open frame alone.
        send_item(random_item(OP_BEGIN));
        send_item(random_item(OP_UNUSED));
        send_item(random_item(OP_FINISH));
    endtask

    // Narrow elements, then one element more than announced.
    task automatic test_narrow_elements();
        cmd_item_t it;
        write_wide(1'b0);
        it = random_item(OP_BEGIN);
        it.param_count = 7'd2;
        send_item(it);
        it = random_item(OP_PARAM);
        it.param_value = 32'h1234_5678;
        send_item(it);
        it.param_value = 32'hFFFF_0000;
        send_item(it);
        it.param_value = 32'h0000_FFFF;
        send_item(it);
        send_item(random_item(OP_FINISH));
    endtask

    // The output is held off while a full frame is offered, so the input stalls.
    task automatic test_back_pressure();
        cmd_item_t it;
        write_wide(1'b1);
        send_idle_pct = 0;
        hold_left     = HOLD_CYCLES;
        it = random_item(OP_BEGIN);
        it.param_count = 7'd10;
        send_item(it);
        repeat (10) send_item(random_item(OP_PARAM));
        send_item(random_item(OP_FINISH));
    endtask

    task automatic test_random_frames(input int send_pct, input int recv_pct,
                                      input logic wide, input int budget);
        cmd_item_t it;
        int        first_item;
        int        cnt;
        int        n_elem;
        logic [1:0] op;
        write_wide(wide);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        first_item    = items_sent;
        while (items_sent - first_item < budget)
        begin
            if ($urandom_range(99) < 12)
            begin
                // Stray item between frames.
                case ($urandom_range(2))
                    0:       op = OP_PARAM;
                    1:       op = OP_FINISH;
                    default: op = OP_UNUSED;
                endcase
                send_item(random_item(op));
            end
            else
            begin
                it  = random_item(OP_BEGIN);
                cnt = it.param_count;
                n_elem = cnt;
                if ($urandom_range(29) == 0)
                begin
                    it.param_count = 7'($urandom_range(127));
                    cnt    = it.param_count;
                    n_elem = $urandom_range(1) ? cnt : $urandom_range(3);
                end
                else if ($urandom_range(4) == 0)
                begin
                    n_elem = (cnt > 0 && $urandom_range(1)) ? $urandom_range(cnt - 1) : cnt + 1;
                end
                send_item(it);
                for (int i = 0; i < n_elem; i++)
                begin
                    if ($urandom_range(19) == 0)
                        send_item(random_item($urandom_range(1) ? OP_BEGIN : OP_UNUSED));
                    send_item(random_item(OP_PARAM));
                end
                send_item(random_item(OP_FINISH));
            end
        end
    endtask

    // Output side: random stalls, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_ch.ready = 1'b0;
            hold_left    = hold_left - 1;
        end
        else
        begin
            rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        frame_byte_t exp_b;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            if (frame_bytes_q.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: expected no byte, got %02h (last %0b end %0b status %0d)",
                         $time, rsp_ch.out_byte, rsp_ch.run_last, rsp_ch.frame_end,
                         rsp_ch.status);
            end
            else
            begin
                exp_b = frame_bytes_q.pop_front();
                if (rsp_ch.out_byte !== exp_b.data)
                begin
                    mismatch_count++;
                    $display("%0t: out_byte expected %02h, got %02h", $time,
                             exp_b.data, rsp_ch.out_byte);
                end
                if (rsp_ch.run_last !== exp_b.last)
                begin
                    mismatch_count++;
                    $display("%0t: run_last expected %0b, got %0b", $time,
                             exp_b.last, rsp_ch.run_last);
                end
                if (rsp_ch.frame_end !== exp_b.fin)
                begin
                    mismatch_count++;
                    $display("%0t: frame_end expected %0b, got %0b", $time,
                             exp_b.fin, rsp_ch.frame_end);
                end
                if (rsp_ch.status !== exp_b.status)
                begin
                    mismatch_count++;
                    $display("%0t: status expected %0d, got %0d", $time,
                             exp_b.status, rsp_ch.status);
                end
            end
        end
    end

    // Ends the run when no transfer of any kind happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.opcode      = OP_BEGIN;
        req_ch.cmd_type    = 8'h00;
        req_ch.dev_type    = 8'h00;
        req_ch.dev_id      = 8'h00;
        req_ch.ctrl_word   = 8'h00;
        req_ch.frame_id    = 31'h0;
        req_ch.param_count = 7'd0;
        req_ch.param_value = 32'h0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.data        = 1'b0;
        rsp_ch.ready       = 1'b0;
        wide_mode          = 1'b1;
        open_frame         = 1'b0;
        frame_sum          = 8'h00;
        announced_cnt      = 0;
        elem_cnt           = 0;
        send_idle_pct      = 0;
        recv_idle_pct      = 0;
        hold_left          = 0;
        items_sent         = 0;
        mismatch_count     = 0;
        stall_cycles       = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_header_extremes();
        test_out_of_order();
        test_narrow_elements();
        test_back_pressure();
        test_random_frames(36, 58, 1'b0, 80);
        test_random_frames(58, 36, 1'b1, 80);
        test_random_frames(0, 0, 1'b0, 40);
        test_random_frames(0, 0, 1'b1, 40);

        wait_for_drain();
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/cfe_pkg.sv
rtl/cfe_req_if.sv
rtl/cfe_rsp_if.sv
rtl/cfe_cfg_if.sv
rtl/cfe_front.sv
rtl/cfe_queue.sv
rtl/cfe_back.sv
rtl/command_frame_encoder.sv
tb/tb_command_frame_encoder.sv
